// ----- design/bba_pkg.sv -----
// shared types and codes for the bitmap block allocator
// no dependencies; imported by bitmap_block_allocator
package bba_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_FORMAT = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_INVALID  = 2'd2
   } status_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_TOTAL    = 1'b0,
      REG_RESERVED = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE,
      S_FORMAT,
      S_RECOUNT,
      S_DONE
   } state_type;

   localparam int CFG_W    = 13;  // width of both registers
   localparam int BLK_W    = 12;  // width of block_number and granted_block
   localparam int STATUS_W = 2;
   localparam int GROUP_W  = 4;   // popcount of one 8-bit group

endpackage

// ----- design/bba_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the allocator's used map
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bitmap_block_allocator.sv -----
// first-fit bitmap block allocator: top level with csr port and sequencer
// depends on bba_pkg and bba_ram
//
// One used bit per block, held in a map ram of ceil(MAX_BLOCKS/WORD_BITS) words of
// WORD_BITS bits (WORD_BITS a power of two). A request is transferred on req_valid and
// req_ready; each request gives exactly one result transfer on rsp_valid and rsp_ready,
// carrying the granted block, a status and the free count after the operation, unless a
// block count write cuts it off first. Allocate scans the map one word per cycle from
// word 0; with no free block it scans every word up to the one holding the last managed
// block. Free reads and writes back one word. Format clears the map at once through
// per-word valid flops and then writes the reserved words. The map ram has a single
// read port, so scans read one word per cycle. A new request is taken while the
// previous result still waits on the rsp side; the sequencer holds the next result
// until that slot is free. Writing the block count register starts a recount of the
// free count over the map as it stands, during which req_ready stays low; the csr port
// itself never stalls (pready is tied high). The map resets to all free with no
// clearing pass, since every word has a valid bit.
module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [BLK_W-1:0]    req_block_number,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BLK_W-1:0]    rsp_granted_block,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CFG_W-1:0]    rsp_free_blocks,
   // csr port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // map geometry
   localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;  // word address
   localparam int PW    = WA_W + 1;                         // pointer, can pass the last word
   localparam int BW_W  = $clog2(WORD_BITS);                // bit within a word
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);           // block counts
   localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;  // common compare width
   localparam int NG    = (WORD_BITS + 7) / 8;              // popcount groups
   localparam int RESET_N = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;

   // csr registers
   logic [CFG_W-1:0] total_ff, total_in;
   logic [CFG_W-1:0] reserved_ff, reserved_in;
   logic             total_wr;

   // sequencer
   state_type        state_ff, state_in;
   logic [PW-1:0]    ptr_ff, ptr_in;
   logic             dq_ok_ff, dq_ok_in;     // ram output holds a word being scanned
   logic [WA_W-1:0]  dq_addr_ff, dq_addr_in; // address of that word
   logic             rd_valid_ff;            // valid bit of the word on the ram output
   logic             valid_ff [WORDS];
   logic             valid_clr_all;
   logic [GROUP_W-1:0] pc_ff [NG];
   logic [GROUP_W-1:0] pc_in [NG];
   logic             pc_ok_ff, pc_ok_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [BLK_W-1:0] blk_ff, blk_in;
   logic [BLK_W-1:0] res_granted_ff, res_granted_in;
   status_type       res_status_ff, res_status_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]    rsp_granted_ff, rsp_granted_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CFG_W-1:0]    rsp_free_ff, rsp_free_in;

   // ram ports
   logic                 rd_en, wr_en;
   logic [WA_W-1:0]      rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data, ram_q;

   // derived values
   logic [CW-1:0]        n_cw, r_cw;
   logic [CNT_W-1:0]     eff_n, nm1, res_r, min_rn;
   logic [WA_W-1:0]      last_w;
   logic [BW_W-1:0]      last_bit;
   logic [PW-1:0]        fmt_full;
   logic [BW_W-1:0]      fmt_part;
   logic                 scan_issue;
   logic                 req_in_range;
   logic [WORD_BITS-1:0] word, in_mask, eff_word, onehot, clr_bits, part_mask;
   logic                 word_found;
   logic [BW_W-1:0]      bit_idx;
   logic [CNT_W-1:0]     pc_sum;

   // ---------------------------------------------------------------
   // csr port: always ready, reads return the stored register
   // ---------------------------------------------------------------
   assign pready   = 1'b1;
   assign total_wr = psel && penable && pwrite && (reg_index_type'(paddr[2]) == REG_TOTAL);

   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[2]))
            REG_TOTAL:    total_in    = pwdata[CFG_W-1:0];
            REG_RESERVED: reserved_in = pwdata[CFG_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_TOTAL:    prdata = {{(32-CFG_W){1'b0}}, total_ff};
         REG_RESERVED: prdata = {{(32-CFG_W){1'b0}}, reserved_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= CFG_W'(4096);
         reserved_ff <= '0;
      end else begin
         total_ff    <= total_in;
         reserved_ff <= reserved_in;
      end
   end

   // ---------------------------------------------------------------
   // block count limits
   // ---------------------------------------------------------------
   // block count above the map size acts as the map size
   assign n_cw     = (CW'(total_ff) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(total_ff);
   assign eff_n    = CNT_W'(n_cw);
   assign nm1      = eff_n - CNT_W'(1);
   assign last_w   = WA_W'(nm1 >> BW_W);
   assign last_bit = nm1[BW_W-1:0];
   // only words up to the one holding the last managed block are scanned
   assign scan_issue = (eff_n != '0) && (ptr_ff <= PW'(last_w));

   // format reservation, clamped to the map size
   assign r_cw     = (CW'(reserved_ff) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                          : CW'(reserved_ff);
   assign res_r    = CNT_W'(r_cw);
   assign min_rn   = (res_r < eff_n) ? res_r : eff_n;
   assign fmt_full = PW'(res_r >> BW_W);
   assign fmt_part = res_r[BW_W-1:0];

   assign req_in_range = CW'(req_block_number) < n_cw;

   // ---------------------------------------------------------------
   // word datapath
   // ---------------------------------------------------------------
   // a word never written since reset or format reads as all free
   assign word = rd_valid_ff ? ram_q : '0;

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         in_mask[j]   = (dq_addr_ff != last_w) || (BW_W'(j) <= last_bit);
         part_mask[j] = BW_W'(j) < fmt_part;
      end
   end

   // bits past the block count look used, so they are never granted or counted
   assign eff_word   = word | ~in_mask;
   assign onehot     = ~eff_word & (eff_word + WORD_BITS'(1));
   assign word_found = ~&eff_word;
   assign clr_bits   = ~word & in_mask;

   always_comb begin
      bit_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (onehot[j]) begin
            bit_idx = bit_idx | BW_W'(j);
         end
      end
   end

   // recount: free bits per 8-bit group, registered, then the sum of the registered group counts
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         pc_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (g * 8 + k < WORD_BITS) begin
               pc_in[g] = pc_in[g] + GROUP_W'(clr_bits[g*8+k]);
            end
         end
      end
   end

   always_comb begin
      pc_sum = '0;
      for (int g = 0; g < NG; g++) begin
         pc_sum = pc_sum + CNT_W'(pc_ff[g]);
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      dq_ok_in       = 1'b0;
      dq_addr_in     = dq_addr_ff;
      pc_ok_in       = 1'b0;
      acc_in         = acc_ff;
      free_in        = free_ff;
      blk_in         = blk_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[WA_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = dq_addr_ff;
      wr_data        = word;
      valid_clr_all  = 1'b0;
      req_ready      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               blk_in         = req_block_number;
               res_granted_in = '0;
               res_status_in  = STAT_OK;
               ptr_in         = '0;
               case (op_type'(req_op))
                  OP_ALLOC: state_in = S_ALLOC;
                  OP_FREE: begin
                     if (req_in_range) begin
                        rd_en      = 1'b1;
                        rd_addr    = WA_W'(req_block_number >> BW_W);
                        dq_addr_in = WA_W'(req_block_number >> BW_W);
                        state_in   = S_FREE;
                     end else begin
                        res_status_in = STAT_INVALID;
                        state_in      = S_DONE;
                     end
                  end
                  OP_FORMAT: begin
                     // whole map reads as free from the next cycle on
                     valid_clr_all = 1'b1;
                     state_in      = S_FORMAT;
                  end
                  default: state_in = S_DONE;  // unused code: no change, status ok
               endcase
            end
         end

         S_ALLOC: begin
            if (scan_issue) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + PW'(1);
               dq_ok_in   = 1'b1;
               dq_addr_in = ptr_ff[WA_W-1:0];
            end
            if (dq_ok_ff && word_found) begin
               wr_en          = 1'b1;
               wr_data        = word | onehot;
               res_granted_in = BLK_W'({dq_addr_ff, bit_idx});
               if (free_ff != '0) begin
                  free_in = free_ff - CNT_W'(1);
               end
               state_in = S_DONE;
            end else if (!dq_ok_ff && !scan_issue) begin
               res_status_in = STAT_NO_SPACE;
               state_in      = S_DONE;
            end
         end

         S_FREE: begin
            if (word[blk_ff[BW_W-1:0]]) begin
               wr_en   = 1'b1;
               wr_data = word & ~(WORD_BITS'(1) << blk_ff[BW_W-1:0]);
               if (free_ff < eff_n) begin
                  free_in = free_ff + CNT_W'(1);
               end
            end else begin
               res_status_in = STAT_INVALID;  // double free
            end
            state_in = S_DONE;
         end

         S_FORMAT: begin
            wr_addr = ptr_ff[WA_W-1:0];
            if (ptr_ff < fmt_full) begin
               wr_en   = 1'b1;
               wr_data = '1;
               ptr_in  = ptr_ff + PW'(1);
            end else if ((ptr_ff == fmt_full) && (fmt_part != '0)) begin
               wr_en   = 1'b1;
               wr_data = part_mask;
               ptr_in  = ptr_ff + PW'(1);
            end else begin
               free_in  = eff_n - min_rn;
               state_in = S_DONE;
            end
         end

         S_RECOUNT: begin
            if (scan_issue) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + PW'(1);
               dq_ok_in   = 1'b1;
               dq_addr_in = ptr_ff[WA_W-1:0];
            end
            pc_ok_in = dq_ok_ff;
            if (pc_ok_ff) begin
               acc_in = acc_ff + pc_sum;
            end
            if (!scan_issue && !dq_ok_ff && !pc_ok_ff) begin
               free_in  = acc_ff;
               state_in = S_IDLE;
            end
         end

         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               rsp_free_in    = CFG_W'(free_ff);
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // a block count write restarts the recount from word 0
      if (total_wr) begin
         state_in = S_RECOUNT;
         ptr_in   = '0;
         acc_in   = '0;
         dq_ok_in = 1'b0;
         pc_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dq_ok_ff     <= 1'b0;
         pc_ok_ff     <= 1'b0;
         free_ff      <= CNT_W'(RESET_N);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dq_ok_ff     <= dq_ok_in;
         pc_ok_ff     <= pc_ok_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      dq_addr_ff     <= dq_addr_in;
      acc_ff         <= acc_in;
      blk_ff         <= blk_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
      pc_ff          <= pc_in;
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // per-word valid bits: reset and format clear them all at once
   always_ff @(posedge clock) begin
      if (reset || valid_clr_all) begin
         for (int w = 0; w < WORDS; w++) begin
            valid_ff[w] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_blocks   = rsp_free_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // the map is never written while the sequencer waits for work
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("map write while idle");

   // the running free count never exceeds the managed block count once settled
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (free_ff <= eff_n))
      else $error("free count above block count");

   // every accepted request leaves idle on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request was dropped");

   // a failed result always reports block zero
   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_granted_block == '0))
      else $error("granted block on failed result");

endmodule
